// ===== sv/gha_pkg.sv =====
// Shared types, constants and handle packing for the generational handle allocator.
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

  localparam int SLOTS      = 32;
  localparam int GEN_BITS   = 16;
  localparam int TYPE_BITS  = 4;
  localparam int INDEX_BITS = 12;

  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_W      = 16;
  localparam int OTYPE_W    = 4;
  localparam int CAP_W      = 6;
  localparam int REL_W      = 12;
  localparam int SIDX_W     = 5;
  localparam int HANDLE_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_NO_SPACE      = 2'd1,
    ST_BAD_CAPACITY  = 2'd2,
    ST_RELEASE_RANGE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OBJECT_TYPE  = 2'd0,
    REG_SLOTS_IN_USE = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    OP_ALLOCATE = 1'b0,
    OP_RELEASE  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [REL_W-1:0]   release_slot;
  } in_word_t;

  typedef struct packed {
    status_t               status;
    logic [SIDX_W-1:0]     slot_index;
    logic [HANDLE_W-1:0]   handle;
  } out_word_t;

  function automatic logic [HANDLE_W-1:0] pack_handle(
    input logic [SLOT_W-1:0]   idx,
    input logic [OTYPE_W-1:0]  otype,
    input logic [GEN_BITS-1:0] gen
  );
    logic [63:0] h;
    h = 64'(idx) & ((64'd1 << INDEX_BITS) - 64'd1);
    h = h | ((64'(otype) & ((64'd1 << TYPE_BITS) - 64'd1)) << INDEX_BITS);
    h = h | (64'(gen) << (INDEX_BITS + TYPE_BITS));
    return h[HANDLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/generational_handle_allocator_unit.sv =====
// Top level of the generational handle allocator.
// Usage:
//   Input channel: drive in_word and raise start; the word is taken at a clock
//   edge where start is high and busy is low. operation selects allocate or
//   release; release_slot names the slot to free.
//   Result channel: each word gives exactly one result, shown on out_word for
//   one cycle with out_valid high. The receiver cannot stall; it must take it.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 object_type,
//   1 slots_in_use) and cfg_data; cfg_ready is always high. Write only when idle.
// Flow: the result is registered at the write-back edge that follows the accepting
//   edge and is then on the ports. busy is high for one cycle after each accept,
//   so a new word is not taken until the last one has been written back.
//   The busy cycle is set by the read-modify-write of the generation RAM: read at
//   the accept edge, increment and write back in the following cycle.
// Allocated bits sit in flops and are priority encoded at accept time.
// Reset (rst_n low, synchronous) clears all allocated bits, marks every
// generation entry invalid (reads as zero), object_type 0, slots_in_use 32.
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_allocator_unit
  import gha_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  output out_word_t                  out_word,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic {
    S_IDLE,
    S_WB
  } state_t;

  state_t               state_r;
  logic [SLOTS-1:0]     used_r;
  logic [SLOTS-1:0]     gen_valid_r;
  logic [OTYPE_W-1:0]   object_type_r;
  logic [CAP_W-1:0]     slots_in_use_r;
  status_t              st_r;
  logic                 grant_r;
  logic [SLOT_W-1:0]    idx_r;
  logic                 rd_valid_r;
  logic                 out_valid_r;
  out_word_t            out_word_r;

  logic [CMP_W-1:0]     eff_cap;
  logic [SLOTS-1:0]     free_vec;
  logic                 found;
  logic [SLOT_W-1:0]    found_idx;
  logic                 accept;
  logic [GEN_BITS-1:0]  rdata;
  logic [GEN_BITS-1:0]  gen_cur;
  logic [GEN_BITS-1:0]  gen_nxt;
  logic                 ram_we;
  logic [SLOT_W-1:0]    rel_idx;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign rel_idx   = in_word.release_slot[SLOT_W-1:0];

  assign eff_cap = (CMP_W'(slots_in_use_r) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS)
                                                             : CMP_W'(slots_in_use_r);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_vec[i] = !used_r[i] && (CMP_W'(i) < eff_cap);
    end
  end

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found     = 1'b1;
        found_idx = SLOT_W'(i);
      end
    end
  end

  assign gen_cur = rd_valid_r ? rdata : '0;

  always_comb begin
    gen_nxt = gen_cur + GEN_BITS'(1);
    if (gen_nxt == '0) begin
      gen_nxt = GEN_BITS'(1);
    end
  end

  assign ram_we = (state_r == S_WB) && grant_r;

  gha_ram #(
    .WIDTH (GEN_BITS),
    .DEPTH (SLOTS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (gen_nxt),
    .raddr (found_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      object_type_r  <= '0;
      slots_in_use_r <= CAP_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_OBJECT_TYPE:  object_type_r  <= cfg_data[OTYPE_W-1:0];
        REG_SLOTS_IN_USE: slots_in_use_r <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_r <= gen_valid_r[found_idx];
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      gen_valid_r <= '0;
      out_valid_r <= 1'b0;
      grant_r     <= 1'b0;
      st_r        <= ST_OK;
      idx_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_WB;
            grant_r <= 1'b0;
            idx_r   <= found_idx;
            if (in_word.operation == OP_ALLOCATE) begin
              if (eff_cap == '0) begin
                st_r <= ST_BAD_CAPACITY;
              end else if (found) begin
                st_r              <= ST_OK;
                grant_r           <= 1'b1;
                used_r[found_idx] <= 1'b1;
              end else begin
                st_r <= ST_NO_SPACE;
              end
            end else begin
              if (CMP_W'(in_word.release_slot) < eff_cap) begin
                st_r            <= ST_OK;
                used_r[rel_idx] <= 1'b0;
              end else begin
                st_r <= ST_RELEASE_RANGE;
              end
            end
          end
        end
        S_WB: begin
          state_r               <= S_IDLE;
          out_valid_r           <= 1'b1;
          out_word_r.status     <= st_r;
          out_word_r.slot_index <= grant_r ? SIDX_W'(idx_r) : '0;
          out_word_r.handle     <= grant_r ? pack_handle(idx_r, object_type_r, gen_nxt)
                                           : '0;
          if (grant_r) begin
            gen_valid_r[idx_r] <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status != ST_OK) |->
      (out_word_r.handle == '0 && out_word_r.slot_index == '0))
    else $error("failed request carries a handle");

  a_grant_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.handle != '0) |-> used_r[idx_r])
    else $error("granted slot not marked allocated");

  a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (gen_nxt != '0))
    else $error("generation written as zero");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_WB))
    else $error("result without a preceding write-back cycle");

endmodule

`default_nettype wire

// ===== sv/gha_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module gha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
